// File: design/atrp_pkg.sv
// Shared types, widths, register indexes and constants for the tilt unit.
// Every other design file refers to this package by scoped names.
package atrp_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int ITER_W = $clog2(ANGLE_ITERATIONS);
	localparam int ATAN_IDX_W = 5;

	localparam int SAMPLE_W = 16;
	localparam int ROLL_W = 16;
	localparam int PITCH_W = 15;
	localparam int TIME_W = 32;
	localparam int RATIO_W = 8;
	localparam int STEP_W = 10;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION_RATIO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP_MS = 2'd1;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd4;
	localparam logic [STEP_W-1:0] STEP_RESET = 10'd20;

	localparam int OPD_W = 17;
	localparam int CORD_W = 34;
	localparam int ACC_W = 24;
	localparam int PRESCALE_SH = 14;
	localparam int ANGLE_SH = 7;
	localparam int ROOT_W = 32;
	localparam logic signed [ACC_W-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [ACC_W-1:0] ROUND_Q20 = 24'sd64;
	localparam logic signed [OPD_W-1:0] ROLL_LIM = 17'sd25736;
	localparam logic signed [OPD_W-1:0] PITCH_LIM = 17'sd12868;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ax;
		logic signed [SAMPLE_W-1:0] ay;
		logic signed [SAMPLE_W-1:0] az;
		logic zero;
		logic [TIME_W-1:0] time_ms;
	} sample_t;

	function automatic logic signed [ACC_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			5'd0: v = 24'sd823550;
			5'd1: v = 24'sd486170;
			5'd2: v = 24'sd256879;
			5'd3: v = 24'sd130396;
			5'd4: v = 24'sd65451;
			5'd5: v = 24'sd32757;
			5'd6: v = 24'sd16383;
			5'd7: v = 24'sd8192;
			5'd8: v = 24'sd4096;
			5'd9: v = 24'sd2048;
			5'd10: v = 24'sd1024;
			5'd11: v = 24'sd512;
			5'd12: v = 24'sd256;
			5'd13: v = 24'sd128;
			5'd14: v = 24'sd64;
			5'd15: v = 24'sd32;
			5'd16: v = 24'sd16;
			5'd17: v = 24'sd8;
			5'd18: v = 24'sd4;
			5'd19: v = 24'sd2;
			5'd20: v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: design/atrp_front.sv
// Front end of the tilt unit: configuration registers, decimation and timestamp.
// Kept samples are classified and handed to the queue; uses atrp_pkg.
module atrp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [atrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [atrp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic push,
	input  logic q_full,
	input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_z,
	output logic enq,
	output atrp_pkg::sample_t enq_item
);

	logic [atrp_pkg::RATIO_W-1:0] ratio_q;
	logic [atrp_pkg::STEP_W-1:0] step_q;
	logic [atrp_pkg::RATIO_W-1:0] count_q;
	logic [atrp_pkg::TIME_W-1:0] time_q;
	logic [atrp_pkg::RATIO_W:0] count_next;
	logic [atrp_pkg::TIME_W-1:0] time_next;
	logic fire;
	logic accept;

	assign count_next = {1'b0, count_q} + {{atrp_pkg::RATIO_W{1'b0}}, 1'b1};
	assign fire = count_next >= {1'b0, ratio_q};
	assign accept = push && !q_full;
	assign time_next = time_q + {{(atrp_pkg::TIME_W-atrp_pkg::STEP_W){1'b0}}, step_q};

	assign enq = accept && fire;
	assign enq_item.ax = accel_x;
	assign enq_item.ay = accel_y;
	assign enq_item.az = accel_z;
	assign enq_item.zero = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
	assign enq_item.time_ms = time_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= atrp_pkg::RATIO_RESET;
			step_q <= atrp_pkg::STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				atrp_pkg::REG_DECIMATION_RATIO: ratio_q <= cfg_data[atrp_pkg::RATIO_W-1:0];
				atrp_pkg::REG_TIME_STEP_MS: step_q <= cfg_data[atrp_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '1;
			time_q <= '0;
		end else if (accept) begin
			if (fire) begin
				count_q <= '0;
				time_q <= time_next;
			end else begin
				count_q <= count_next[atrp_pkg::RATIO_W-1:0];
			end
		end
	end

endmodule

// File: design/atrp_queue.sv
// Two-entry queue of kept samples between the front end and the angle engine.
// Uses the sample type of atrp_pkg.
module atrp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  atrp_pkg::sample_t wr_item,
	output logic full,
	input  logic rd_en,
	output atrp_pkg::sample_t rd_item,
	output logic valid
);

	atrp_pkg::sample_t entries_q [atrp_pkg::QUEUE_DEPTH];
	logic [atrp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [atrp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [atrp_pkg::QCNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = cnt_q == atrp_pkg::QCNT_W'(atrp_pkg::QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign rd_item = entries_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == atrp_pkg::QPTR_W'(atrp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == atrp_pkg::QPTR_W'(atrp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/atrp_cordic.sv
// Iterative CORDIC vectoring unit giving atan2(y, x) in clamped Q2.13 radians.
// One rotation step per cycle; table and constants come from atrp_pkg.
module atrp_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [atrp_pkg::OPD_W-1:0] x_in,
	input  logic signed [atrp_pkg::OPD_W-1:0] y_in,
	input  logic signed [atrp_pkg::OPD_W-1:0] lim,
	output logic busy,
	output logic signed [atrp_pkg::ROLL_W-1:0] angle
);

	logic busy_q;
	logic fin_q;
	logic [atrp_pkg::ITER_W-1:0] i_q;
	logic signed [atrp_pkg::CORD_W-1:0] x_q;
	logic signed [atrp_pkg::CORD_W-1:0] y_q;
	logic signed [atrp_pkg::ACC_W-1:0] acc_q;
	logic signed [atrp_pkg::OPD_W-1:0] lim_q;
	logic signed [atrp_pkg::ROLL_W-1:0] angle_q;

	logic in_zero;
	logic signed [atrp_pkg::CORD_W-1:0] xs;
	logic signed [atrp_pkg::CORD_W-1:0] ys;
	logic signed [atrp_pkg::CORD_W-1:0] x_pre;
	logic signed [atrp_pkg::CORD_W-1:0] y_pre;
	logic signed [atrp_pkg::ACC_W-1:0] acc_pre;
	logic signed [atrp_pkg::CORD_W-1:0] dx;
	logic signed [atrp_pkg::CORD_W-1:0] dy;
	logic signed [atrp_pkg::ACC_W-1:0] step_angle;
	logic signed [atrp_pkg::ACC_W-1:0] rounded;
	logic signed [atrp_pkg::ACC_W-1:0] shifted;
	logic signed [atrp_pkg::OPD_W-1:0] q_val;
	logic signed [atrp_pkg::OPD_W-1:0] q_clamp;

	assign in_zero = (x_in == '0) && (y_in == '0);
	assign xs = {{(atrp_pkg::CORD_W-atrp_pkg::OPD_W){x_in[atrp_pkg::OPD_W-1]}}, x_in}
		<<< atrp_pkg::PRESCALE_SH;
	assign ys = {{(atrp_pkg::CORD_W-atrp_pkg::OPD_W){y_in[atrp_pkg::OPD_W-1]}}, y_in}
		<<< atrp_pkg::PRESCALE_SH;

	// A vector in the left half-plane is first turned by a quarter turn.
	always_comb begin
		x_pre = xs;
		y_pre = ys;
		acc_pre = '0;
		if (xs < 0) begin
			if (ys >= 0) begin
				x_pre = ys;
				y_pre = -xs;
				acc_pre = atrp_pkg::HALF_PI_Q20;
			end else begin
				x_pre = -ys;
				y_pre = xs;
				acc_pre = -atrp_pkg::HALF_PI_Q20;
			end
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign step_angle = atrp_pkg::atan_q20(atrp_pkg::ATAN_IDX_W'(i_q));

	assign rounded = acc_q + atrp_pkg::ROUND_Q20;
	assign shifted = rounded >>> atrp_pkg::ANGLE_SH;
	assign q_val = shifted[atrp_pkg::OPD_W-1:0];

	always_comb begin
		q_clamp = q_val;
		if (q_val > lim_q) begin
			q_clamp = lim_q;
		end else if (q_val < -lim_q) begin
			q_clamp = -lim_q;
		end
	end

	assign busy = busy_q;
	assign angle = angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= !in_zero;
			fin_q <= 1'b0;
			i_q <= '0;
		end else if (busy_q) begin
			if (fin_q) begin
				busy_q <= 1'b0;
				fin_q <= 1'b0;
			end else begin
				if (i_q == atrp_pkg::ITER_W'(atrp_pkg::ANGLE_ITERATIONS - 1)) begin
					fin_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_pre;
			y_q <= y_pre;
			acc_q <= acc_pre;
			lim_q <= lim;
			if (in_zero) begin
				angle_q <= '0;
			end
		end else if (busy_q) begin
			if (fin_q) begin
				angle_q <= q_clamp[atrp_pkg::ROLL_W-1:0];
			end else if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				acc_q <= acc_q + step_angle;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				acc_q <= acc_q - step_angle;
			end
		end
	end

endmodule

// File: design/atrp_back.sv
// Angle engine of the tilt unit: squares, integer square root, two CORDIC passes
// and the result register. Uses atrp_pkg and instantiates atrp_cordic.
module atrp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  atrp_pkg::sample_t q_head,
	output logic q_pop,
	input  logic pop,
	output logic empty,
	output logic signed [atrp_pkg::ROLL_W-1:0] roll_angle,
	output logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle,
	output logic [atrp_pkg::TIME_W-1:0] time_ms,
	output logic zero_vector
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR = 3'd1;
	localparam logic [2:0] ST_SUM = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_PITCH_GO = 3'd4;
	localparam logic [2:0] ST_PITCH = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	localparam int EXT_W = atrp_pkg::OPD_W - atrp_pkg::SAMPLE_W;

	logic [2:0] state_q;
	logic res_valid_q;
	logic signed [atrp_pkg::SAMPLE_W-1:0] ax_q;
	logic signed [atrp_pkg::SAMPLE_W-1:0] ay_q;
	logic signed [atrp_pkg::SAMPLE_W-1:0] az_q;
	logic zero_q;
	logic [atrp_pkg::TIME_W-1:0] time_q;
	logic [atrp_pkg::ROOT_W-1:0] sq_y_q;
	logic [atrp_pkg::ROOT_W-1:0] sq_z_q;
	logic [atrp_pkg::ROOT_W-1:0] s_q;
	logic [atrp_pkg::ROOT_W-1:0] root_q;
	logic [atrp_pkg::ROOT_W-1:0] bit_q;
	logic signed [atrp_pkg::ROLL_W-1:0] roll_q;
	logic signed [atrp_pkg::ROLL_W-1:0] roll_out_q;
	logic signed [atrp_pkg::PITCH_W-1:0] pitch_out_q;
	logic [atrp_pkg::TIME_W-1:0] time_out_q;
	logic zero_out_q;

	logic signed [2*atrp_pkg::SAMPLE_W-1:0] prod_y;
	logic signed [2*atrp_pkg::SAMPLE_W-1:0] prod_z;
	logic [atrp_pkg::ROOT_W-1:0] trial;
	logic signed [atrp_pkg::OPD_W-1:0] ay_ext;
	logic signed [atrp_pkg::OPD_W-1:0] az_ext;
	logic signed [atrp_pkg::OPD_W-1:0] ax_ext;
	logic cord_start;
	logic signed [atrp_pkg::OPD_W-1:0] cord_x;
	logic signed [atrp_pkg::OPD_W-1:0] cord_y;
	logic signed [atrp_pkg::OPD_W-1:0] cord_lim;
	logic cord_busy;
	logic signed [atrp_pkg::ROLL_W-1:0] cord_angle;
	logic out_free;

	assign ay_ext = {{EXT_W{q_head.ay[atrp_pkg::SAMPLE_W-1]}}, q_head.ay};
	assign az_ext = {{EXT_W{q_head.az[atrp_pkg::SAMPLE_W-1]}}, q_head.az};
	assign ax_ext = {{EXT_W{ax_q[atrp_pkg::SAMPLE_W-1]}}, ax_q};

	assign prod_y = ay_q * ay_q;
	assign prod_z = az_q * az_q;
	assign trial = root_q + bit_q;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_free = !res_valid_q || pop;

	always_comb begin
		cord_start = 1'b0;
		cord_x = -az_ext;
		cord_y = -ay_ext;
		cord_lim = atrp_pkg::ROLL_LIM;
		if (state_q == ST_IDLE) begin
			cord_start = q_valid;
		end else if (state_q == ST_PITCH_GO) begin
			cord_start = !cord_busy;
			cord_x = {1'b0, root_q[atrp_pkg::OPD_W-2:0]};
			cord_y = ax_ext;
			cord_lim = atrp_pkg::PITCH_LIM;
		end
	end

	atrp_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cord_start),
		.x_in(cord_x),
		.y_in(cord_y),
		.lim(cord_lim),
		.busy(cord_busy),
		.angle(cord_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (bit_q[0]) begin
						state_q <= ST_PITCH_GO;
					end
				end
				ST_PITCH_GO: begin
					if (!cord_busy) begin
						state_q <= ST_PITCH;
					end
				end
				ST_PITCH: begin
					if (!cord_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					ax_q <= q_head.ax;
					ay_q <= q_head.ay;
					az_q <= q_head.az;
					zero_q <= q_head.zero;
					time_q <= q_head.time_ms;
				end
			end
			ST_SQR: begin
				sq_y_q <= prod_y[atrp_pkg::ROOT_W-1:0];
				sq_z_q <= prod_z[atrp_pkg::ROOT_W-1:0];
			end
			ST_SUM: begin
				s_q <= sq_y_q + sq_z_q;
				root_q <= '0;
				bit_q <= atrp_pkg::ROOT_W'(1) << (atrp_pkg::ROOT_W - 2);
			end
			ST_ROOT: begin
				if (s_q >= trial) begin
					s_q <= s_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_PITCH_GO: begin
				if (!cord_busy) begin
					roll_q <= cord_angle;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					roll_out_q <= roll_q;
					pitch_out_q <= cord_angle[atrp_pkg::PITCH_W-1:0];
					time_out_q <= time_q;
					zero_out_q <= zero_q;
				end
			end
			default: ;
		endcase
	end

	assign empty = !res_valid_q;
	assign roll_angle = roll_out_q;
	assign pitch_angle = pitch_out_q;
	assign time_ms = time_out_q;
	assign zero_vector = zero_out_q;

endmodule

// File: design/accel_tilt_roll_pitch_unit.sv
// Top level of the accelerometer tilt unit: front end, sample queue and angle engine.
// Depends on atrp_pkg, atrp_front, atrp_queue and atrp_back.

// Roll and pitch from raw three-axis accelerometer samples. Samples are decimated by
// register 0, and each kept sample advances the timestamp by register 1 and yields
// one result with roll = atan2(-ay, -az) in Q2.13 radians and pitch = atan2(ax,
// sqrt(ay^2 + az^2)) in Q1.13 radians; an all-zero sample gives zero angles and sets
// zero_vector. The input side takes a sample in any cycle while full is low. A
// two-entry queue holds kept samples ahead of the angle engine, which takes each
// through 16 square-root steps, then the pitch pass of the one shared CORDIC unit
// (16 iterations plus rounding); the roll pass runs alongside the root. A finished
// result waits in the output register while the engine takes the next one.
module accel_tilt_roll_pitch_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [atrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [atrp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic push,
	output logic full,
	input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_z,
	output logic empty,
	input  logic pop,
	output logic signed [atrp_pkg::ROLL_W-1:0] roll_angle,
	output logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle,
	output logic [atrp_pkg::TIME_W-1:0] time_ms,
	output logic zero_vector
);

	logic enq;
	atrp_pkg::sample_t enq_item;
	logic q_full;
	logic q_valid;
	logic q_pop;
	atrp_pkg::sample_t q_head;

	assign full = q_full;

	atrp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.q_full(q_full),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.enq(enq),
		.enq_item(enq_item)
	);

	atrp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(enq),
		.wr_item(enq_item),
		.full(q_full),
		.rd_en(q_pop),
		.rd_item(q_head),
		.valid(q_valid)
	);

	atrp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.roll_angle(roll_angle),
		.pitch_angle(pitch_angle),
		.time_ms(time_ms),
		.zero_vector(zero_vector)
	);

endmodule

// File: design/atrp_checker.sv
// Port-level checks for the tilt unit, attached to the top level by bind.
// Depends on atrp_pkg for widths and angle limits.
module atrp_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic signed [atrp_pkg::ROLL_W-1:0] roll_angle,
	input logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle,
	input logic [atrp_pkg::TIME_W-1:0] time_ms,
	input logic zero_vector
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(roll_angle) && $stable(pitch_angle)
			&& $stable(time_ms) && $stable(zero_vector))
		else $error("Waiting result changed before it was taken.");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> roll_angle <= atrp_pkg::ROLL_LIM && roll_angle >= -atrp_pkg::ROLL_LIM)
		else $error("Roll angle outside of plus or minus pi.");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pitch_angle <= atrp_pkg::PITCH_LIM && pitch_angle >= -atrp_pkg::PITCH_LIM)
		else $error("Pitch angle outside of plus or minus half pi.");

	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && zero_vector |-> roll_angle == '0 && pitch_angle == '0)
		else $error("All-zero sample produced a nonzero angle.");

endmodule

bind accel_tilt_roll_pitch_unit atrp_checker u_atrp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.roll_angle(roll_angle),
	.pitch_angle(pitch_angle),
	.time_ms(time_ms),
	.zero_vector(zero_vector)
);

// File: tb/accel_tilt_roll_pitch_unit_tb.sv
// Self-checking testbench for the accelerometer tilt unit: a queue-fed driver and a monitor
// that predicts decimation, timestamp, roll and pitch for every accepted sample.
// Depends on atrp_pkg and the accel_tilt_roll_pitch_unit RTL.
module accel_tilt_roll_pitch_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [atrp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [atrp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 60;
	localparam int ATAN_LEN = 24;
	localparam longint PRESCALE = 16384;
	localparam longint QUARTER_TURN_Q20 = 1647099;
	localparam longint ROLL_LIMIT = 25736;
	localparam longint PITCH_LIMIT = 12868;
	localparam longint ATAN_STEPS [0:ATAN_LEN-1] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0, 0, 0
	};

	typedef struct {
		logic signed [atrp_pkg::SAMPLE_W-1:0] ax;
		logic signed [atrp_pkg::SAMPLE_W-1:0] ay;
		logic signed [atrp_pkg::SAMPLE_W-1:0] az;
		bit hold;
	} sample_item_t;

	typedef struct {
		logic signed [atrp_pkg::ROLL_W-1:0] roll;
		logic signed [atrp_pkg::PITCH_W-1:0] pitch;
		logic [atrp_pkg::TIME_W-1:0] time_ms;
		logic zero;
	} tilt_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [atrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [atrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic signed [atrp_pkg::SAMPLE_W-1:0] accel_x = '0;
	logic signed [atrp_pkg::SAMPLE_W-1:0] accel_y = '0;
	logic signed [atrp_pkg::SAMPLE_W-1:0] accel_z = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [atrp_pkg::ROLL_W-1:0] roll_angle;
	logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle;
	logic [atrp_pkg::TIME_W-1:0] time_ms;
	logic zero_vector;

	logic [atrp_pkg::RATIO_W-1:0] tilt_ratio = atrp_pkg::RATIO_RESET;
	logic [atrp_pkg::STEP_W-1:0] tilt_step = atrp_pkg::STEP_RESET;
	logic [atrp_pkg::RATIO_W-1:0] tilt_count = '1;
	logic [atrp_pkg::TIME_W-1:0] tilt_clock = '0;

	sample_item_t tilt_pending [$];
	tilt_result_t tilt_expected [$];
	sample_item_t next_sample;
	sample_item_t seen_sample;
	tilt_result_t want;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int mismatch_count = 0;
	int result_count = 0;
	int cycle_count = 0;

	accel_tilt_roll_pitch_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.empty(empty),
		.pop(pop),
		.roll_angle(roll_angle),
		.pitch_angle(pitch_angle),
		.time_ms(time_ms),
		.zero_vector(zero_vector)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Vectoring CORDIC: angle of (nx, ny) in Q2.13, clamped to +/- lim.
	function automatic longint vector_angle(input longint ny, input longint nx, input longint lim);
		longint x;
		longint y;
		longint acc;
		longint t;
		longint q;
		int i;
		if (nx == 0 && ny == 0)
			return 0;
		x = nx * PRESCALE;
		y = ny * PRESCALE;
		acc = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y;
				y = -x;
				x = t;
				acc = QUARTER_TURN_Q20;
			end else begin
				t = -y;
				y = x;
				x = t;
				acc = -QUARTER_TURN_Q20;
			end
		end
		for (i = 0; i < atrp_pkg::ANGLE_ITERATIONS && i < ATAN_LEN; i++) begin
			t = x;
			if (y >= 0) begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				acc += ATAN_STEPS[i];
			end else begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				acc -= ATAN_STEPS[i];
			end
		end
		q = (acc + 64) >>> 7;
		if (q > lim)
			q = lim;
		if (q < -lim)
			q = -lim;
		return q;
	endfunction

	function automatic bit predict_tilt(input sample_item_t s, output tilt_result_t r);
		int unsigned next_count;
		longint ax;
		longint ay;
		longint az;
		longint root;
		next_count = tilt_count + 1;
		if (next_count < tilt_ratio) begin
			tilt_count = next_count[7:0];
			return 1'b0;
		end
		tilt_count = '0;
		tilt_clock = tilt_clock + tilt_step;
		ax = s.ax;
		ay = s.ay;
		az = s.az;
		r.time_ms = tilt_clock;
		r.zero = (ax == 0 && ay == 0 && az == 0);
		if (r.zero) begin
			r.roll = '0;
			r.pitch = '0;
		end else begin
			r.roll = atrp_pkg::ROLL_W'(vector_angle(-ay, -az, ROLL_LIMIT));
			root = longint'(int_sqrt(longint'(ay * ay + az * az)));
			r.pitch = atrp_pkg::PITCH_W'(vector_angle(ax, root, PITCH_LIMIT));
		end
		return 1'b1;
	endfunction

	function automatic logic signed [atrp_pkg::SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(4))
			0: return -16'sd32768;
			1: return -16'sd1;
			2: return 16'sd0;
			3: return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	function automatic sample_item_t random_sample();
		sample_item_t s;
		s.hold = 1'b0;
		s.ax = atrp_pkg::SAMPLE_W'($urandom);
		s.ay = atrp_pkg::SAMPLE_W'($urandom);
		s.az = atrp_pkg::SAMPLE_W'($urandom);
		case ($urandom_range(9))
			6, 7: begin
				s.ax = atrp_pkg::SAMPLE_W'(int'($urandom_range(8)) - 4);
				s.ay = atrp_pkg::SAMPLE_W'(int'($urandom_range(8)) - 4);
				s.az = atrp_pkg::SAMPLE_W'(int'($urandom_range(8)) - 4);
			end
			8: begin
				if ($urandom_range(1))
					s.ay = '0;
				if ($urandom_range(1))
					s.az = '0;
				if ($urandom_range(3) == 0)
					s.ax = '0;
			end
			9: begin
				s.ax = pick_extreme();
				s.ay = pick_extreme();
				s.az = pick_extreme();
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH %s", what);
		mismatch_count++;
	endtask

	task automatic queue_sample(input int x, input int y, input int z);
		sample_item_t s;
		s.ax = atrp_pkg::SAMPLE_W'(x);
		s.ay = atrp_pkg::SAMPLE_W'(y);
		s.az = atrp_pkg::SAMPLE_W'(z);
		s.hold = 1'b0;
		tilt_pending.push_back(s);
	endtask

	task automatic write_reg(input logic [atrp_pkg::CFG_IDX_W-1:0] idx,
			input logic [atrp_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == atrp_pkg::REG_DECIMATION_RATIO)
			tilt_ratio = data[atrp_pkg::RATIO_W-1:0];
		else if (idx == atrp_pkg::REG_TIME_STEP_MS)
			tilt_step = data[atrp_pkg::STEP_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// A dropped sample leaves no trace in the result queue, so settle for a while after draining.
	task automatic wait_idle();
		while (tilt_pending.size() > 0 || push || tilt_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [atrp_pkg::CFG_DATA_W-1:0] ratio_data,
			input logic [atrp_pkg::CFG_DATA_W-1:0] step_data, input int send_pct,
			input int stall_pct, input int n, input int hold_at);
		sample_item_t s;
		int k;
		wait_idle();
		write_reg(atrp_pkg::REG_DECIMATION_RATIO, ratio_data);
		write_reg(atrp_pkg::REG_TIME_STEP_MS, step_data);
		send_idle_pct = send_pct;
		pop_stall_pct = stall_pct;
		for (k = 0; k < n; k++) begin
			s = random_sample();
			s.hold = (k == hold_at);
			tilt_pending.push_back(s);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (tilt_pending.size() > 0 && $urandom_range(99) >= send_idle_pct
					&& !(tilt_pending[0].hold && (push || tilt_expected.size() > 0))) begin
				next_sample = tilt_pending.pop_front();
				push <= 1'b1;
				accel_x <= next_sample.ax;
				accel_y <= next_sample.ay;
				accel_z <= next_sample.az;
			end else begin
				push <= 1'b0;
				accel_x <= atrp_pkg::SAMPLE_W'($urandom);
				accel_y <= atrp_pkg::SAMPLE_W'($urandom);
				accel_z <= atrp_pkg::SAMPLE_W'($urandom);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (tilt_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result, time_ms %0d", time_ms));
				end else begin
					want = tilt_expected.pop_front();
					if (roll_angle !== want.roll)
						report_mismatch($sformatf("roll_angle of result %0d: got %0d, expected %0d",
							result_count, roll_angle, want.roll));
					if (pitch_angle !== want.pitch)
						report_mismatch($sformatf("pitch_angle of result %0d: got %0d, expected %0d",
							result_count, pitch_angle, want.pitch));
					if (time_ms !== want.time_ms)
						report_mismatch($sformatf("time_ms of result %0d: got %0d, expected %0d",
							result_count, time_ms, want.time_ms));
					if (zero_vector !== want.zero)
						report_mismatch($sformatf("zero_vector of result %0d: got %b, expected %b",
							result_count, zero_vector, want.zero));
				end
				result_count++;
			end
			if (push && !full) begin
				seen_sample.ax = accel_x;
				seen_sample.ay = accel_y;
				seen_sample.az = accel_z;
				seen_sample.hold = 1'b0;
				if (predict_tilt(seen_sample, want))
					tilt_expected.push_back(want);
			end
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("accel_tilt_roll_pitch_unit regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings keep one sample in four, starting with the first.
		repeat (8) tilt_pending.push_back(random_sample());
		wait_idle();
		// The count now exceeds the new ratio, so the next sample is kept.
		write_reg(atrp_pkg::REG_DECIMATION_RATIO, 10'd2);
		tilt_pending.push_back(random_sample());
		wait_idle();
		write_reg(atrp_pkg::REG_DECIMATION_RATIO, 10'd1);
		write_reg(atrp_pkg::REG_TIME_STEP_MS, 10'd1000);
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, atrp_pkg::CFG_DATA_W'($urandom));

		queue_sample(0, 0, 0);
		queue_sample(32767, 0, 0);
		queue_sample(-32768, 0, 0);
		queue_sample(1, 0, 0);
		queue_sample(0, 0, -32768);
		queue_sample(0, 0, 32767);
		queue_sample(0, 1, 32767);
		queue_sample(0, -1, 32767);
		queue_sample(0, 32767, 0);
		queue_sample(0, -32768, 0);
		queue_sample(-32768, -32768, -32768);
		queue_sample(32767, 32767, 32767);
		queue_sample(32767, -32768, -32768);
		queue_sample(-32768, 32767, 32767);
		queue_sample(0, -1, 0);
		queue_sample(0, 0, 1);
		queue_sample(0, 0, -1);
		queue_sample(-1, -1, -1);
		queue_sample(5, -3, 0);

		run_phase(10'd1, 10'd1000, 0, 0, 350, -1);
		run_phase(10'd0, 10'd0, 67, 0, 300, 120);
		run_phase(10'd3, 10'd1023, 0, 67, 300, -1);
		run_phase(10'($urandom_range(8, 2)), 10'($urandom_range(1000)), 21, 21, 350, 200);
		run_phase(10'h3FF, 10'd7, 0, 0, 300, -1);
		wait_idle();

		if (mismatch_count == 0)
			$display("accel_tilt_roll_pitch_unit regression: pass");
		else
			$display("accel_tilt_roll_pitch_unit regression: fail");
		$finish;
	end
endmodule
